@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the sequencer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge out of reset
`define TVSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never hold out of reset
`define TVSS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ hw/rtl/tvss_pkg.sv @@
// types, codes and helpers for the timed valve step sequencer
package tvss_pkg;

  localparam int CNT_W     = 16;
  localparam int SC_W      = 5;
  localparam int PHASE_W   = 3;
  localparam int EV_W      = 2;
  localparam int REQ_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] SAT_MAX       = 16'hFFFF;
  localparam logic [CNT_W-1:0] REPEATS_RESET = 16'd1;
  localparam int PROGRESS_WEIGHT = 2;
  localparam int SETTLE_STEPS    = 4;

  localparam logic [PHASE_W-1:0] PHC_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PHC_GB   = 3'd1;
  localparam logic [PHASE_W-1:0] PHC_SB   = 3'd2;
  localparam logic [PHASE_W-1:0] PHC_DW   = 3'd3;
  localparam logic [PHASE_W-1:0] PHC_SA   = 3'd4;
  localparam logic [PHASE_W-1:0] PHC_GA   = 3'd5;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_GB   = 6'b000010,
    PH_SB   = 6'b000100,
    PH_DW   = 6'b001000,
    PH_SA   = 6'b010000,
    PH_GA   = 6'b100000
  } phase_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_START  = 3'd1,
    REQ_PAUSE  = 3'd2,
    REQ_RESUME = 3'd3,
    REQ_LOAD   = 3'd4
  } req_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 2'd0,
    EV_GOOD  = 2'd1,
    EV_ERROR = 2'd2
  } rep_ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GPB   = 2'd0,
    CFG_GPA   = 2'd1,
    CFG_TOTAL = 2'd2,
    CFG_STEPS = 2'd3
  } cfg_reg_t;

  function automatic logic [PHASE_W-1:0] phase_code(phase_t p);
    logic [PHASE_W-1:0] c;
    case (p)
      PH_IDLE: c = PHC_IDLE;
      PH_GB:   c = PHC_GB;
      PH_SB:   c = PHC_SB;
      PH_DW:   c = PHC_DW;
      PH_SA:   c = PHC_SA;
      PH_GA:   c = PHC_GA;
      default: c = PHC_IDLE;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/timed_valve_step_sequencer.sv @@
// top level of the timed valve step sequencer
//
// channel | handshake             | transfer
// in_     | in_valid / in_ready   | tick, start, pause, resume or step table load
// out_    | out_valid / out_ready | status after the update, one per input transfer
// cfg_    | cfg_we                | pause lengths, repeat total, step count
//
// one input transfer per clock while in_ready is high; the whole update, zero-length
// phases included, is done in the cycle of the transfer, fed by two step table read
// ports addressed a cycle ahead; each result is registered in the output or skid slot
// in_ready drops only while both output slots hold results not yet taken
// synchronous reset clears control and config (repeat total to 1), not the step table
module timed_valve_step_sequencer import tvss_pkg::*; #(
  parameter int MAX_STEPS  = 16,
  parameter int NUM_VALVES = 8,
  parameter int TIME_WIDTH = 16,
  localparam int IdxW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1,
  localparam int CntW = $clog2(MAX_STEPS + 1),
  localparam int CfgW = (TIME_WIDTH > CNT_W) ? TIME_WIDTH : CNT_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic                  in_pressure_ok,
  input  logic [IdxW-1:0]       in_load_index,
  input  logic [TIME_WIDTH-1:0] in_step_pause_before,
  input  logic [TIME_WIDTH-1:0] in_step_dwell,
  input  logic [TIME_WIDTH-1:0] in_step_pause_after,
  input  logic [NUM_VALVES-1:0] in_step_valves,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [NUM_VALVES-1:0] out_open_valves,
  output logic [PHASE_W-1:0]    out_phase,
  output logic [CNT_W-1:0]      out_repeat_now,
  output logic [CntW-1:0]       out_step_now,
  output logic [CNT_W-1:0]      out_dwell_ticks,
  output logic [CNT_W-1:0]      out_progress,
  output logic [EV_W-1:0]       out_repeat_event,
  output logic                  out_run_finished,
  output logic                  out_run_ok,
  output logic [CNT_W-1:0]      out_done_count,
  output logic [CNT_W-1:0]      out_error_count,
  output logic                  out_held,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CfgW-1:0]       cfg_wdata
);

  typedef struct packed {
    logic [NUM_VALVES-1:0] open_valves;
    logic [PHASE_W-1:0]    phase;
    logic [CNT_W-1:0]      repeat_now;
    logic [CntW-1:0]       step_now;
    logic [CNT_W-1:0]      dwell_ticks;
    logic [CNT_W-1:0]      progress;
    logic [EV_W-1:0]       repeat_event;
    logic                  run_finished;
    logic                  run_ok;
    logic [CNT_W-1:0]      done_count;
    logic [CNT_W-1:0]      error_count;
    logic                  held;
  } res_t;

  localparam int ResW = $bits(res_t);

  logic            item_acc;
  res_t            res_in, res_out;
  logic [ResW-1:0] buf_out;

  assign item_acc = in_valid && in_ready;

  tvss_seq #(
    .MAX_STEPS  (MAX_STEPS),
    .NUM_VALVES (NUM_VALVES),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .item_acc          (item_acc),
    .req_type          (in_req_type),
    .pressure_ok       (in_pressure_ok),
    .load_index        (in_load_index),
    .step_pause_before (in_step_pause_before),
    .step_dwell        (in_step_dwell),
    .step_pause_after  (in_step_pause_after),
    .step_valves       (in_step_valves),
    .res_valves        (res_in.open_valves),
    .res_phase         (res_in.phase),
    .res_repeat        (res_in.repeat_now),
    .res_step          (res_in.step_now),
    .res_dwell         (res_in.dwell_ticks),
    .res_progress      (res_in.progress),
    .res_event         (res_in.repeat_event),
    .res_finished      (res_in.run_finished),
    .res_ok            (res_in.run_ok),
    .res_done          (res_in.done_count),
    .res_error         (res_in.error_count),
    .res_held          (res_in.held)
  );

  tvss_skid #(.WIDTH(ResW)) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_acc),
    .push_data (res_in),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .pop_ready (out_ready),
    .out_data  (buf_out)
  );

  assign res_out = res_t'(buf_out);

  assign out_open_valves  = res_out.open_valves;
  assign out_phase        = res_out.phase;
  assign out_repeat_now   = res_out.repeat_now;
  assign out_step_now     = res_out.step_now;
  assign out_dwell_ticks  = res_out.dwell_ticks;
  assign out_progress     = res_out.progress;
  assign out_repeat_event = res_out.repeat_event;
  assign out_run_finished = res_out.run_finished;
  assign out_run_ok       = res_out.run_ok;
  assign out_done_count   = res_out.done_count;
  assign out_error_count  = res_out.error_count;
  assign out_held         = res_out.held;

endmodule

@@ hw/rtl/tvss_ram.sv @@
// generic single write port ram with one registered read port
module tvss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/tvss_seq.sv @@
// sequencer core: phase state, step table memories and per-item update
`include "assert_macros.svh"

module tvss_seq import tvss_pkg::*; #(
  parameter int MAX_STEPS  = 16,
  parameter int NUM_VALVES = 8,
  parameter int TIME_WIDTH = 16,
  localparam int IdxW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1,
  localparam int CntW = $clog2(MAX_STEPS + 1),
  localparam int CfgW = (TIME_WIDTH > CNT_W) ? TIME_WIDTH : CNT_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CfgW-1:0]       cfg_wdata,
  input  logic                  item_acc,
  input  logic [REQ_W-1:0]      req_type,
  input  logic                  pressure_ok,
  input  logic [IdxW-1:0]       load_index,
  input  logic [TIME_WIDTH-1:0] step_pause_before,
  input  logic [TIME_WIDTH-1:0] step_dwell,
  input  logic [TIME_WIDTH-1:0] step_pause_after,
  input  logic [NUM_VALVES-1:0] step_valves,
  output logic [NUM_VALVES-1:0] res_valves,
  output logic [PHASE_W-1:0]    res_phase,
  output logic [CNT_W-1:0]      res_repeat,
  output logic [CntW-1:0]       res_step,
  output logic [CNT_W-1:0]      res_dwell,
  output logic [CNT_W-1:0]      res_progress,
  output logic [EV_W-1:0]       res_event,
  output logic                  res_finished,
  output logic                  res_ok,
  output logic [CNT_W-1:0]      res_done,
  output logic [CNT_W-1:0]      res_error,
  output logic                  res_held
);

  localparam int ProgW = CNT_W + 1;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] pre;
    logic [TIME_WIDTH-1:0] dwell;
    logic [TIME_WIDTH-1:0] after;
    logic [NUM_VALVES-1:0] valves;
  } entry_t;

  localparam int EntW = $bits(entry_t);

  typedef struct packed {
    phase_t                phase;
    logic [TIME_WIDTH-1:0] cdown;
    logic [CntW-1:0]       step;
    logic [CNT_W-1:0]      rep;
    logic [CNT_W-1:0]      done;
    logic [CNT_W-1:0]      err;
    logic [CNT_W-1:0]      dwell;
    logic [NUM_VALVES-1:0] valves;
    rep_ev_t               ev;
    logic                  fin;
    logic                  ok;
  } seq_t;

  typedef struct packed {
    entry_t                e0;
    entry_t                ecur;
    entry_t                enxt;
    logic [CntW-1:0]       base;
    logic [CntW-1:0]       act;
    logic [TIME_WIDTH-1:0] gpb;
    logic [TIME_WIDTH-1:0] gpa;
    logic [CNT_W-1:0]      total;
  } ctx_t;

  // configuration
  logic [TIME_WIDTH-1:0] gpb_r, gpa_r;
  logic [CNT_W-1:0]      total_r;
  logic [SC_W-1:0]       steps_r;
  logic [CntW-1:0]       act;

  // sequencer state
  seq_t  seq_r, seq_nxt, res_st;
  logic  paused_r, paused_nxt, paused_res;

  // step table
  logic              wr_en;
  entry_t            wr_entry;
  logic [IdxW-1:0]   addr_cur, addr_next;
  logic [EntW-1:0]   rd_cur, rd_next;
  entry_t            e0_r;
  logic              fwd_valid_r;
  logic [IdxW-1:0]   fwd_idx_r;
  entry_t            fwd_data_r;
  ctx_t              ctx;
  logic [ProgW-1:0]  prog;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpb_r   <= '0;
      gpa_r   <= '0;
      total_r <= REPEATS_RESET;
      steps_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GPB:   gpb_r   <= cfg_wdata[TIME_WIDTH-1:0];
        CFG_GPA:   gpa_r   <= cfg_wdata[TIME_WIDTH-1:0];
        CFG_TOTAL: total_r <= cfg_wdata[CNT_W-1:0];
        CFG_STEPS: steps_r <= cfg_wdata[SC_W-1:0];
        default:   steps_r <= steps_r;
      endcase
    end
  end

  assign act = (32'(steps_r) > MAX_STEPS) ? CntW'(MAX_STEPS) : CntW'(steps_r);

  // table write and read ports, read addresses follow the next step index
  assign wr_en    = item_acc && (req_type == REQ_LOAD) && (32'(load_index) < MAX_STEPS);
  assign wr_entry = '{pre: step_pause_before, dwell: step_dwell,
                      after: step_pause_after, valves: step_valves};
  assign addr_cur  = seq_nxt.step[IdxW-1:0];
  assign addr_next = seq_nxt.step[IdxW-1:0] + IdxW'(1);

  tvss_ram #(.WIDTH(EntW), .DEPTH(MAX_STEPS)) u_ram_cur (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_index),
    .wr_data (wr_entry),
    .rd_addr (addr_cur),
    .rd_data (rd_cur)
  );

  tvss_ram #(.WIDTH(EntW), .DEPTH(MAX_STEPS)) u_ram_next (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_index),
    .wr_data (wr_entry),
    .rd_addr (addr_next),
    .rd_data (rd_next)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    fwd_idx_r  <= load_index;
    fwd_data_r <= wr_entry;
    if (wr_en && (load_index == '0)) begin
      e0_r <= wr_entry;
    end
  end

  always_comb begin
    ctx.e0    = e0_r;
    ctx.ecur  = (fwd_valid_r && (fwd_idx_r == seq_r.step[IdxW-1:0]))
                ? fwd_data_r : entry_t'(rd_cur);
    ctx.enxt  = (fwd_valid_r && (fwd_idx_r == seq_r.step[IdxW-1:0] + IdxW'(1)))
                ? fwd_data_r : entry_t'(rd_next);
    ctx.base  = seq_r.step;
    ctx.act   = act;
    ctx.gpb   = gpb_r;
    ctx.gpa   = gpa_r;
    ctx.total = total_r;
  end

  function automatic entry_t pick_entry(ctx_t c, logic [CntW-1:0] s);
    entry_t e;
    if (s == c.base) begin
      e = c.ecur;
    end else if (s == '0) begin
      e = c.e0;
    end else begin
      e = c.enxt;
    end
    return e;
  endfunction

  function automatic seq_t do_enter(seq_t st_in, phase_t p, ctx_t c);
    seq_t   st;
    entry_t e;
    phase_t q;
    st = st_in;
    e  = pick_entry(c, st.step);
    q  = p;
    if ((p == PH_SB) && (st.step >= c.act)) begin
      q = PH_GA;
    end
    st.phase = q;
    case (q)
      PH_GB: st.cdown = c.gpb;
      PH_SB: st.cdown = e.pre;
      PH_DW: begin
        st.valves = e.valves;
        st.dwell  = '0;
        st.cdown  = (e.dwell == '0) ? TIME_WIDTH'(1) : e.dwell;
      end
      PH_SA: st.cdown = e.after;
      PH_GA: st.cdown = c.gpa;
      default: st.cdown = '0;
    endcase
    return st;
  endfunction

  function automatic seq_t do_finish(seq_t st_in, logic good, ctx_t c);
    seq_t           st;
    logic [CNT_W:0] nrep;
    st = st_in;
    if (good) begin
      st.ev = EV_GOOD;
      if (st.done != SAT_MAX) begin
        st.done = st.done + 1'b1;
      end
    end else begin
      st.ev = EV_ERROR;
      if (st.err != SAT_MAX) begin
        st.err = st.err + 1'b1;
      end
    end
    nrep   = {1'b0, st.rep} + 1'b1;
    st.rep = nrep[CNT_W-1:0];
    if ((nrep >= {1'b0, c.total}) || nrep[CNT_W]) begin
      st.phase = PH_IDLE;
      st.cdown = '0;
      st.fin   = 1'b1;
      st.ok    = (st.err == '0);
    end else begin
      st.step  = '0;
      st.dwell = '0;
      st       = do_enter(st, PH_GB, c);
    end
    return st;
  endfunction

  function automatic seq_t do_expire(seq_t st_in, ctx_t c);
    seq_t st;
    st = st_in;
    case (st.phase)
      PH_GB: begin
        st.step = '0;
        st      = do_enter(st, PH_SB, c);
      end
      PH_SB: st = do_enter(st, PH_DW, c);
      PH_DW: begin
        st.valves = '0;
        st        = do_enter(st, PH_SA, c);
      end
      PH_SA: begin
        st.step = st.step + 1'b1;
        st      = do_enter(st, PH_SB, c);
      end
      PH_GA:   st = do_finish(st, 1'b1, c);
      default: st = st_in;
    endcase
    return st;
  endfunction

  // zero-length phases, at most one repeat end per item
  function automatic seq_t do_settle(seq_t st_in, ctx_t c);
    seq_t st;
    st = st_in;
    for (int i = 0; i < SETTLE_STEPS; i++) begin
      if ((st.cdown == '0) && (st.phase != PH_IDLE) && (st.phase != PH_DW) &&
          !((st.phase == PH_GA) && (st.ev != EV_NONE))) begin
        st = do_expire(st, c);
      end
    end
    return st;
  endfunction

  always_comb begin
    seq_t st;
    st        = seq_r;
    st.ev     = EV_NONE;
    st.fin    = 1'b0;
    st.ok     = 1'b0;
    paused_res = paused_r;
    case (req_type)
      REQ_TICK: begin
        if (!paused_r && (seq_r.phase != PH_IDLE)) begin
          if ((seq_r.phase == PH_DW) && !pressure_ok) begin
            st.valves = '0;
            st        = do_finish(st, 1'b0, ctx);
            st        = do_settle(st, ctx);
          end else begin
            if ((st.phase == PH_DW) && (st.dwell != SAT_MAX)) begin
              st.dwell = st.dwell + 1'b1;
            end
            if (st.cdown > TIME_WIDTH'(1)) begin
              st.cdown = st.cdown - 1'b1;
            end else begin
              st.cdown = '0;
              st       = do_expire(st, ctx);
              st       = do_settle(st, ctx);
            end
          end
        end
      end
      REQ_START: begin
        if (ctx.act == '0) begin
          st.fin = 1'b1;
          st.ok  = 1'b0;
        end else begin
          st.rep    = '0;
          st.done   = '0;
          st.err    = '0;
          st.step   = '0;
          st.dwell  = '0;
          st.valves = '0;
          st        = do_enter(st, PH_GB, ctx);
          st        = do_settle(st, ctx);
        end
      end
      REQ_PAUSE:  paused_res = 1'b1;
      REQ_RESUME: paused_res = 1'b0;
      REQ_LOAD:   paused_res = paused_r;
      default:    paused_res = paused_r;
    endcase
    res_st = st;
  end

  assign seq_nxt    = item_acc ? res_st : seq_r;
  assign paused_nxt = item_acc ? paused_res : paused_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= '{phase: PH_IDLE, ev: EV_NONE, default: '0};
      paused_r <= 1'b0;
    end else begin
      seq_r    <= seq_nxt;
      paused_r <= paused_nxt;
    end
  end

  assign prog = ProgW'(res_st.step) * ProgW'(PROGRESS_WEIGHT) + ProgW'(res_st.dwell);

  assign res_valves   = res_st.valves;
  assign res_phase    = phase_code(res_st.phase);
  assign res_repeat   = res_st.rep;
  assign res_step     = res_st.step;
  assign res_dwell    = res_st.dwell;
  assign res_progress = (prog > ProgW'(SAT_MAX)) ? SAT_MAX : prog[CNT_W-1:0];
  assign res_event    = res_st.ev;
  assign res_finished = res_st.fin;
  assign res_ok       = res_st.ok;
  assign res_done     = res_st.done;
  assign res_error    = res_st.err;
  assign res_held     = paused_res;

  `TVSS_ASSERT(a_valves_only_dwell, (seq_r.phase != PH_DW) |-> (seq_r.valves == '0), "valves open outside a dwell")
  `TVSS_ASSERT(a_dwell_has_time, (seq_r.phase == PH_DW) |-> (seq_r.cdown != '0), "dwell with no time left")
  `TVSS_ASSERT(a_fault_counts, (item_acc && (req_type == REQ_TICK) && !paused_r && (seq_r.phase == PH_DW) && !pressure_ok) |=> ((seq_r.err != $past(seq_r.err)) || ($past(seq_r.err) == SAT_MAX)), "pressure fault not counted")

endmodule

@@ hw/rtl/tvss_skid.sv @@
// two-slot output buffer: result register plus skid register
`include "assert_macros.svh"

module tvss_skid #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [WIDTH-1:0] out_data_r, out_data_nxt;
  logic [WIDTH-1:0] skid_data_r, skid_data_nxt;
  logic             take;

  assign take = out_valid_r && pop_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = push;
        skid_data_nxt  = push_data;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TVSS_NEVER(a_skid_behind_out, skid_valid_r && !out_valid_r, "skid slot full with output slot empty")
  `TVSS_ASSERT(a_stall_to_skid, (out_valid_r && !pop_ready && push) |=> skid_valid_r, "stalled transfer lost")
  `TVSS_ASSERT(a_skid_drains, (skid_valid_r && pop_ready) |=> !skid_valid_r, "skid slot not drained")

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for the timed valve step sequencer, directed and random traffic
module tb import tvss_pkg::*;;

  localparam int TBL_N = 16;
  localparam int GAP_MAX = 9;
  localparam int WATCHDOG = 400;
  localparam logic [REQ_W-1:0] REQ_TOP = {REQ_W{1'b1}};

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             ok;
    logic [3:0]       idx;
    logic [15:0]      pb;
    logic [15:0]      dw;
    logic [15:0]      pa;
    logic [7:0]       mask;
  } cmd_t;

  typedef struct packed {
    logic [7:0]         valves;
    logic [PHASE_W-1:0] ph;
    logic [CNT_W-1:0]   rep;
    logic [SC_W-1:0]    step_idx;
    logic [CNT_W-1:0]   dwell;
    logic [CNT_W-1:0]   prog;
    logic [EV_W-1:0]    ev;
    logic               fin;
    logic               ok;
    logic [CNT_W-1:0]   good;
    logic [CNT_W-1:0]   bad;
    logic               held;
  } status_t;

  typedef struct packed {
    logic [15:0] pb;
    logic [15:0] dw;
    logic [15:0] pa;
    logic [7:0]  mask;
  } entry_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [REQ_W-1:0]   in_req_type = '0;
  logic               in_pressure_ok = 1'b0;
  logic [3:0]         in_load_index = '0;
  logic [15:0]        in_step_pause_before = '0;
  logic [15:0]        in_step_dwell = '0;
  logic [15:0]        in_step_pause_after = '0;
  logic [7:0]         in_step_valves = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_open_valves;
  logic [PHASE_W-1:0] out_phase;
  logic [CNT_W-1:0]   out_repeat_now;
  logic [SC_W-1:0]    out_step_now;
  logic [CNT_W-1:0]   out_dwell_ticks;
  logic [CNT_W-1:0]   out_progress;
  logic [EV_W-1:0]    out_repeat_event;
  logic               out_run_finished;
  logic               out_run_ok;
  logic [CNT_W-1:0]   out_done_count;
  logic [CNT_W-1:0]   out_error_count;
  logic               out_held;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]   cfg_wdata = '0;

  timed_valve_step_sequencer DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sequencer model state
  int unsigned g_before, g_after, rep_total, steps_cfg;
  logic [PHASE_W-1:0] ph;
  int unsigned tick_left, cur_step, cur_rep, n_good, n_bad, dwell_cnt;
  bit on_hold;
  logic [7:0] valve_mask;
  entry_t seq_tbl [TBL_N];
  logic [EV_W-1:0] rep_ev;
  bit run_end, run_good;

  status_t status_q[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_wait = 0;
  bit result_taken = 1'b0;
  bit stall_on = 1'b1;

  function automatic void reset_model();
    g_before = 0;
    g_after = 0;
    rep_total = 32'(REPEATS_RESET);
    steps_cfg = 0;
    ph = PHC_IDLE;
    tick_left = 0;
    cur_step = 0;
    cur_rep = 0;
    n_good = 0;
    n_bad = 0;
    dwell_cnt = 0;
    on_hold = 1'b0;
    valve_mask = '0;
  endfunction

  function automatic int unsigned steps_used();
    return (steps_cfg > TBL_N) ? TBL_N : steps_cfg;
  endfunction

  function automatic void enter_phase(logic [PHASE_W-1:0] p);
    if (p == PHC_SB && cur_step >= steps_used()) p = PHC_GA;
    ph = p;
    case (p)
      PHC_GB: tick_left = g_before;
      PHC_SB: tick_left = 32'(seq_tbl[cur_step].pb);
      PHC_DW: begin
        valve_mask = seq_tbl[cur_step].mask;
        dwell_cnt = 0;
        tick_left = (seq_tbl[cur_step].dw == 0) ? 1 : 32'(seq_tbl[cur_step].dw);
      end
      PHC_SA: tick_left = 32'(seq_tbl[cur_step].pa);
      PHC_GA: tick_left = g_after;
      default: tick_left = 0;
    endcase
  endfunction

  function automatic void close_repeat(bit well);
    if (well) begin
      rep_ev = EV_GOOD;
      if (n_good < SAT_MAX) n_good++;
    end else begin
      rep_ev = EV_ERROR;
      if (n_bad < SAT_MAX) n_bad++;
    end
    cur_rep++;
    if (cur_rep >= rep_total || cur_rep > SAT_MAX) begin
      cur_rep = cur_rep & SAT_MAX;
      ph = PHC_IDLE;
      tick_left = 0;
      run_end = 1'b1;
      run_good = (n_bad == 0);
    end else begin
      cur_step = 0;
      dwell_cnt = 0;
      enter_phase(PHC_GB);
    end
  endfunction

  function automatic void phase_timeout();
    case (ph)
      PHC_GB: begin
        cur_step = 0;
        enter_phase(PHC_SB);
      end
      PHC_SB: enter_phase(PHC_DW);
      PHC_DW: begin
        valve_mask = '0;
        enter_phase(PHC_SA);
      end
      PHC_SA: begin
        cur_step++;
        enter_phase(PHC_SB);
      end
      PHC_GA: close_repeat(1'b1);
      default: ;
    endcase
  endfunction

  // pass through zero-length phases, at most one repeat ending per request
  function automatic void skip_zero();
    while (tick_left == 0 && ph != PHC_IDLE && ph != PHC_DW) begin
      if (ph == PHC_GA && rep_ev != EV_NONE) return;
      phase_timeout();
    end
  endfunction

  function automatic status_t apply_cmd(cmd_t c);
    status_t s;
    int unsigned p;
    rep_ev = EV_NONE;
    run_end = 1'b0;
    run_good = 1'b0;
    case (c.req)
      REQ_TICK: begin
        if (!on_hold && ph != PHC_IDLE) begin
          if (ph == PHC_DW && !c.ok) begin
            valve_mask = '0;
            close_repeat(1'b0);
            skip_zero();
          end else begin
            if (ph == PHC_DW && dwell_cnt < SAT_MAX) dwell_cnt++;
            if (tick_left > 1) begin
              tick_left--;
            end else begin
              tick_left = 0;
              phase_timeout();
              skip_zero();
            end
          end
        end
      end
      REQ_START: begin
        if (steps_used() == 0) begin
          run_end = 1'b1;
        end else begin
          cur_rep = 0;
          n_good = 0;
          n_bad = 0;
          cur_step = 0;
          dwell_cnt = 0;
          valve_mask = '0;
          enter_phase(PHC_GB);
          skip_zero();
        end
      end
      REQ_PAUSE: on_hold = 1'b1;
      REQ_RESUME: on_hold = 1'b0;
      REQ_LOAD: seq_tbl[c.idx] = '{c.pb, c.dw, c.pa, c.mask};
      default: ;
    endcase
    p = cur_step * PROGRESS_WEIGHT + dwell_cnt;
    if (p > SAT_MAX) p = 32'(SAT_MAX);
    s.valves = valve_mask;
    s.ph = ph;
    s.rep = CNT_W'(cur_rep);
    s.step_idx = SC_W'(cur_step);
    s.dwell = CNT_W'(dwell_cnt);
    s.prog = CNT_W'(p);
    s.ev = rep_ev;
    s.fin = run_end;
    s.ok = run_good;
    s.good = CNT_W'(n_good);
    s.bad = CNT_W'(n_bad);
    s.held = on_hold;
    return s;
  endfunction

  function automatic void cmp(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_status(status_t want, status_t got);
    cmp("open_valves", 32'(want.valves), 32'(got.valves));
    cmp("phase", 32'(want.ph), 32'(got.ph));
    cmp("repeat_now", 32'(want.rep), 32'(got.rep));
    cmp("step_now", 32'(want.step_idx), 32'(got.step_idx));
    cmp("dwell_ticks", 32'(want.dwell), 32'(got.dwell));
    cmp("progress", 32'(want.prog), 32'(got.prog));
    cmp("repeat_event", 32'(want.ev), 32'(got.ev));
    cmp("run_finished", 32'(want.fin), 32'(got.fin));
    cmp("run_ok", 32'(want.ok), 32'(got.ok));
    cmp("done_count", 32'(want.good), 32'(got.good));
    cmp("error_count", 32'(want.bad), 32'(got.bad));
    cmp("held", 32'(want.held), 32'(got.held));
  endfunction

  always @(posedge clk) begin
    status_t want, got;
    result_taken = 1'b0;
    if (rst_n && out_valid && out_ready) begin
      result_taken = 1'b1;
      got = {out_open_valves, out_phase, out_repeat_now, out_step_now, out_dwell_ticks,
             out_progress, out_repeat_event, out_run_finished, out_run_ok,
             out_done_count, out_error_count, out_held};
      if (status_q.size() == 0) begin
        $display("%0t status transfer with no request outstanding", $time);
        mismatches++;
      end else begin
        want = status_q.pop_front();
        compare_status(want, got);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (result_taken) rx_wait = stall_on ? $urandom_range(0, GAP_MAX) : 0;
      if (rx_wait != 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(cmd_t c);
    int unsigned gap;
    gap = stall_on ? $urandom_range(0, GAP_MAX) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= c.req;
    in_pressure_ok <= c.ok;
    in_load_index <= c.idx;
    in_step_pause_before <= c.pb;
    in_step_dwell <= c.dw;
    in_step_pause_after <= c.pa;
    in_step_valves <= c.mask;
    do @(posedge clk); while (!in_ready);
    status_q.push_back(apply_cmd(c));
  endtask

  function automatic cmd_t cmd_of(logic [REQ_W-1:0] r);
    cmd_t c;
    c = cmd_t'({$urandom(), $urandom()});
    c.req = r;
    c.ok = 1'b1;
    return c;
  endfunction

  task automatic send_req(logic [REQ_W-1:0] r);
    send_cmd(cmd_of(r));
  endtask

  task automatic send_tick(logic ok);
    cmd_t c;
    c = cmd_of(REQ_TICK);
    c.ok = ok;
    send_cmd(c);
  endtask

  task automatic load_entry(int unsigned idx, int unsigned pb, int unsigned dw,
                            int unsigned pa, int unsigned mask);
    cmd_t c;
    c = cmd_of(REQ_LOAD);
    c.idx = 4'(idx);
    c.pb = 16'(pb);
    c.dw = 16'(dw);
    c.pa = 16'(pa);
    c.mask = 8'(mask);
    send_cmd(c);
  endtask

  task automatic run_out(int unsigned cap);
    int unsigned n;
    n = 0;
    while (ph != PHC_IDLE && n < cap) begin
      send_tick(1'b1);
      n++;
    end
  endtask

  task automatic tick_until(logic [PHASE_W-1:0] target, int unsigned cap);
    int unsigned n;
    n = 0;
    while (ph != target && n < cap) begin
      send_tick(1'b1);
      n++;
    end
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CNT_W'(v);
    @(posedge clk);
    case (idx)
      CFG_GPB: g_before = v & 16'hFFFF;
      CFG_GPA: g_after = v & 16'hFFFF;
      CFG_TOTAL: rep_total = v & 16'hFFFF;
      CFG_STEPS: steps_cfg = v & 5'h1F;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(int unsigned gpb, int unsigned gpa, int unsigned total,
                           int unsigned steps);
    quiesce();
    write_reg(CFG_GPB, gpb);
    write_reg(CFG_GPA, gpa);
    write_reg(CFG_TOTAL, total);
    write_reg(CFG_STEPS, steps);
  endtask

  function automatic int unsigned pick_time();
    return ($urandom_range(0, 31) == 0) ? $urandom_range(0, 16'hFFFF) : $urandom_range(0, 3);
  endfunction

  task automatic test_idle_requests();
    int r;
    send_tick(1'b1);
    send_tick(1'b0);
    send_req(REQ_PAUSE);
    send_tick(1'b1);
    send_req(REQ_PAUSE);
    send_req(REQ_RESUME);
    send_req(REQ_RESUME);
    for (r = int'(REQ_LOAD) + 1; r <= int'(REQ_TOP); r++) send_req(REQ_W'(r));
    // start with no steps configured
    send_req(REQ_START);
  endtask

  task automatic test_table_load();
    int unsigned i;
    load_entry(TBL_N - 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    load_entry(0, 0, 0, 0, 0);
    for (i = 0; i < TBL_N; i++)
      load_entry(i, $urandom_range(0, 2), $urandom_range(0, 3), $urandom_range(0, 2),
                 $urandom_range(0, 8'hFF));
  endtask

  task automatic test_basic_run();
    configure(2, 1, 2, 3);
    send_req(REQ_START);
    run_out(300);
  endtask

  task automatic test_zero_phases();
    load_entry(0, 0, 0, 0, 8'h81);
    load_entry(1, 0, 0, 0, 8'h7E);
    // zero repeats still runs one
    configure(0, 0, 0, 2);
    send_req(REQ_START);
    run_out(50);
    configure(0, 0, 3, 2);
    send_req(REQ_START);
    run_out(50);
  endtask

  task automatic test_pressure_fault();
    configure(1, 1, 3, 2);
    send_req(REQ_START);
    tick_until(PHC_DW, 50);
    send_tick(1'b0);
    tick_until(PHC_DW, 50);
    send_tick(1'b1);
    send_tick(1'b0);
    run_out(200);
  endtask

  task automatic test_hold();
    configure(1, 2, 2, 3);
    send_req(REQ_START);
    send_tick(1'b1);
    tick_until(PHC_DW, 50);
    send_req(REQ_PAUSE);
    send_tick(1'b1);
    send_tick(1'b0);
    send_req(REQ_PAUSE);
    send_req(REQ_RESUME);
    send_req(REQ_RESUME);
    run_out(300);
  endtask

  task automatic test_restart();
    configure(1, 1, 3, 2);
    send_req(REQ_START);
    tick_until(PHC_DW, 50);
    send_tick(1'b1);
    send_req(REQ_START);
    run_out(300);
  endtask

  task automatic test_step_count_edges();
    // oversized step count acts as a full table
    configure(0, 0, 1, 31);
    send_req(REQ_START);
    run_out(600);
    configure(0, 0, 1, TBL_N);
    send_req(REQ_START);
    run_out(600);
    // step count dropped to zero mid run, second repeat parks in global after
    load_entry(0, 0, 2, 0, 8'hA5);
    configure(0, 0, 3, 2);
    send_req(REQ_START);
    send_tick(1'b1);
    quiesce();
    write_reg(CFG_STEPS, 0);
    run_out(20);
    // live table change and step count cut during a run
    configure(1, 0, 2, 4);
    send_req(REQ_START);
    tick_until(PHC_SA, 50);
    load_entry(2, 1, 2, 1, 8'h3C);
    quiesce();
    write_reg(CFG_STEPS, 2);
    run_out(300);
  endtask

  task automatic test_register_extremes();
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
    send_req(REQ_START);
    repeat (3) send_tick(1'b1);
    quiesce();
    write_reg(CFG_GPB, 0);
    send_req(REQ_START);
    tick_until(PHC_GA, 50);
    repeat (3) send_tick(1'b1);
    configure(3, 3, 2, 1);
    send_req(REQ_START);
    run_out(100);
  endtask

  task automatic test_long_dwell();
    stall_on = 1'b0;
    load_entry(1, 0, 200, 1, 8'hC3);
    configure(0, 0, 1, 2);
    send_req(REQ_START);
    run_out(400);
    load_entry(1, 1, 2, 1, 8'h18);
    stall_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned round, counted, roll;
    cmd_t c;
    bit ignored;
    for (round = 0; round < 6; round++) begin
      stall_on = (round != 0);
      configure($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 4),
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6));
      counted = 0;
      while (counted < 30) begin
        roll = $urandom_range(0, 99);
        if (ph == PHC_IDLE && roll < 40) c = cmd_of(REQ_START);
        else if (roll < 62) c = cmd_of(REQ_TICK);
        else if (roll < 66) c = cmd_of(REQ_START);
        else if (roll < 70) c = cmd_of(REQ_PAUSE);
        else if (roll < 78) c = cmd_of(REQ_RESUME);
        else if (roll < 96) c = cmd_of(REQ_LOAD);
        else c = cmd_of(REQ_W'($urandom_range(int'(REQ_LOAD) + 1, int'(REQ_TOP))));
        if (c.req == REQ_TICK) c.ok = ($urandom_range(0, 11) != 0);
        if (c.req == REQ_LOAD) begin
          c.pb = 16'(pick_time());
          c.dw = 16'(pick_time());
          c.pa = 16'(pick_time());
        end
        ignored = (c.req == REQ_TICK && (on_hold || ph == PHC_IDLE)) || c.req > REQ_LOAD;
        send_cmd(c);
        if (!ignored) counted++;
        if (round != 0 && counted % 10 == 0) stall_on = ($urandom_range(0, 3) != 0);
      end
    end
  endtask

  task automatic wrap_up();
    quiesce();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  endtask

  initial begin
    reset_model();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_idle_requests();
    test_table_load();
    test_basic_run();
    test_zero_phases();
    test_pressure_fault();
    test_hold();
    test_restart();
    test_step_count_edges();
    test_register_extremes();
    test_long_dwell();
    test_random_traffic();
    wrap_up();
  end

endmodule
